// File: rtl/adaptive_replacement_cache_core_macros.svh
// Assertion macros for the ARC core.
`ifndef ADAPTIVE_REPLACEMENT_CACHE_CORE_MACROS_SVH
`define ADAPTIVE_REPLACEMENT_CACHE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define ARC_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("arc assertion failed");
`define ARC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("arc assertion failed");
`else
`define ARC_ASSERT(lbl, expr)
`define ARC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/arc_pkg.sv
package arc_pkg;

  localparam int CAPACITY_MAX_DEF = 16;
  localparam int SLOT_COUNT_DEF   = 32;
  localparam int CAP_W            = 5;

  // List codes held per slot
  localparam logic [2:0] LST_EMPTY = 3'd0;
  localparam logic [2:0] LST_T1    = 3'd1;
  localparam logic [2:0] LST_T2    = 3'd2;
  localparam logic [2:0] LST_B1    = 3'd3;
  localparam logic [2:0] LST_B2    = 3'd4;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [31:0]        key;
    logic signed [31:0] write_value;
  } in_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] read_value;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_RDVAL,
    ST_DECIDE,
    ST_DIV,
    ST_ADAPT,
    ST_DROP,
    ST_REPL_DET,
    ST_REPL_PUSH,
    ST_SELF_DET,
    ST_PUSH,
    ST_FIN
  } state_t;

endpackage

// File: rtl/arc_div.sv
module arc_div #(
  parameter int W = 6
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);

  localparam int NW = $clog2(W + 1);

  logic [W:0]    rem_r, rem_nxt;
  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  dvs_r;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    shifted;

  // One quotient bit per cycle, restoring form
  always_comb begin
    shifted  = {rem_r[W-1:0], quo_r[W-1]};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (cnt_r != '0) begin
      if (shifted >= {1'b0, dvs_r}) begin
        rem_nxt = shifted - {1'b0, dvs_r};
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == NW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= NW'(W);
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: rtl/adaptive_replacement_cache_core.sv
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  arc_pkg::in_t  (cmd, key, write_value)
// out      output     out_valid/out_stall  arc_pkg::out_t (hit, read_value)
// cfg      input      cfg_we               cfg_data = capacity
// From acceptance to the output register the path is shortest on a get miss, longer on a
// resident hit or on a miss that drops and replaces, and longest on a ghost hit: the key
// scan reads the key memory one slot a cycle and the ghost quotient takes one bit a cycle.
// The block returns to idle before the next acceptance.
// One item is in flight at a time; in_stall is high from acceptance until its
// result enters the output register, which then waits for out_stall to drop.
// Reset is synchronous: all lists empty, p cleared, capacity 16. No clearing pass.
`include "adaptive_replacement_cache_core_macros.svh"

module adaptive_replacement_cache_core #(
  parameter int CAPACITY_MAX = arc_pkg::CAPACITY_MAX_DEF,
  parameter int SLOT_COUNT   = arc_pkg::SLOT_COUNT_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  arc_pkg::in_t              in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output arc_pkg::out_t             out_data,
  input  logic                      cfg_we,
  input  logic [arc_pkg::CAP_W-1:0] cfg_data
);

  localparam int IW = $clog2(SLOT_COUNT);
  localparam int CW = $clog2(SLOT_COUNT + 1);
  localparam int PW = $clog2(CAPACITY_MAX + 1);
  localparam int SW = CW + 2;
  localparam int CAPACITY_MAX_RESET = 16;

  // Per-slot state: key and value in memories, list and rank in flops
  logic [31:0]   key_mem [SLOT_COUNT];
  logic [31:0]   val_mem [SLOT_COUNT];
  logic [2:0]    list_r  [SLOT_COUNT];
  logic [2:0]    list_nxt[SLOT_COUNT];
  logic [IW-1:0] rank_r  [SLOT_COUNT];
  logic [IW-1:0] rank_nxt[SLOT_COUNT];
  logic [CW-1:0] counts_r  [4];
  logic [CW-1:0] counts_nxt[4];

  arc_pkg::state_t state_r, state_nxt;
  arc_pkg::in_t    in_q_r;
  arc_pkg::out_t   out_data_r;
  logic            out_valid_r;

  logic [arc_pkg::CAP_W-1:0] cap_r;
  logic [PW-1:0]             cap_eff;
  logic [PW-1:0]             p_r;

  logic [IW-1:0] scan_cnt_r, cmp_idx_r, s_r;
  logic          cmp_v_r, found_r;
  logic [31:0]   key_q_r, val_q_r, wval_r;
  logic          res_r, ghost_r, ghost_b2_r, hit_r;
  logic [31:0]   rv_r;
  logic          do_repl_r;
  logic [2:0]    drop_lst_r, to_lst_r;
  logic [IW-1:0] tail_r;

  // Shared datapath controls
  logic          det_en, push_en;
  logic [IW-1:0] det_slot, push_slot;
  logic [2:0]    push_lst;
  logic [2:0]    det_l;
  logic [IW-1:0] det_rank;
  logic          mem_we;

  logic [2:0]    tail_lst;
  logic [CW-1:0] tail_n;
  logic          tail_ok;
  logic [IW-1:0] tail_idx;
  logic          free_ok;
  logic [IW-1:0] free_idx;
  logic [2:0]    rep_from;

  logic [2:0]    s_lst;
  logic          dec_res, dec_ghost;
  logic [SW-1:0] c_w, t1_w, t1b1_w, all_w;
  logic          m_drop, m_repl;
  logic [2:0]    m_drop_lst;

  logic          div_start, div_done, div_b2;
  logic [CW-1:0] div_a, div_b, div_q, delta;
  logic [SW-1:0] p_sum;
  logic [PW-1:0] p_new;

  logic in_acc, out_take, out_load;

  assign in_acc   = in_valid && !in_stall;
  assign out_take = out_valid_r && !out_stall;
  assign in_stall = (state_r != arc_pkg::ST_IDLE);

  // Effective capacity: zero reads as one, clip at the maximum
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = PW'(1);
    end else if (32'(cap_r) > CAPACITY_MAX) begin
      cap_eff = PW'(CAPACITY_MAX);
    end else begin
      cap_eff = PW'(cap_r);
    end
  end

  assign c_w    = SW'(cap_eff);
  assign t1_w   = SW'(counts_r[0]);
  assign t1b1_w = SW'(counts_r[0]) + SW'(counts_r[2]);
  assign all_w  = t1b1_w + SW'(counts_r[1]) + SW'(counts_r[3]);

  // Classify the scanned entry
  assign s_lst     = list_r[s_r];
  assign dec_res   = found_r && (s_lst == arc_pkg::LST_T1 || s_lst == arc_pkg::LST_T2);
  assign dec_ghost = found_r && (s_lst == arc_pkg::LST_B1 || s_lst == arc_pkg::LST_B2);

  // Miss path: trim against the L1 and L1+L2 limits
  always_comb begin
    m_drop     = 1'b0;
    m_repl     = 1'b0;
    m_drop_lst = arc_pkg::LST_B1;
    if (t1b1_w == c_w) begin
      m_drop = 1'b1;
      if (t1_w < c_w) begin
        m_drop_lst = arc_pkg::LST_B1;
        m_repl     = 1'b1;
      end else begin
        m_drop_lst = arc_pkg::LST_T1;
      end
    end else if (t1b1_w < c_w && all_w >= c_w) begin
      m_repl = 1'b1;
      if (all_w == (c_w << 1)) begin
        m_drop     = 1'b1;
        m_drop_lst = arc_pkg::LST_B2;
      end
    end
  end

  // REPLACE picks the list to trim from the current counts and p
  always_comb begin
    if (counts_r[0] != '0 &&
        ((ghost_r && ghost_b2_r && t1_w == SW'(p_r)) || t1_w > SW'(p_r))) begin
      rep_from = arc_pkg::LST_T1;
    end else begin
      rep_from = arc_pkg::LST_T2;
    end
  end

  // Tail search: the one slot of the list whose rank is count - 1
  assign tail_lst = (state_r == arc_pkg::ST_DROP) ? drop_lst_r : rep_from;
  assign tail_n   = counts_r[2'(tail_lst - 3'd1)];

  always_comb begin
    tail_ok  = 1'b0;
    tail_idx = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (tail_n != '0 && list_r[i] == tail_lst &&
          CW'(rank_r[i]) + CW'(1) == tail_n) begin
        tail_ok  = 1'b1;
        tail_idx = tail_idx | IW'(i);
      end
    end
  end

  // Lowest empty slot for an install
  always_comb begin
    free_ok  = 1'b0;
    free_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (list_r[i] == arc_pkg::LST_EMPTY) begin
        free_ok  = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  // Ghost adaptation: delta from the quotient of ghost counts, p saturates.
  // The divider loads its operands in DECIDE, before the ghost list is registered.
  assign div_b2 = (state_r == arc_pkg::ST_DECIDE) ? (s_lst == arc_pkg::LST_B2) : ghost_b2_r;
  assign div_a  = div_b2 ? counts_r[2] : counts_r[3];
  assign div_b  = div_b2 ? counts_r[3] : counts_r[2];

  arc_div #(.W(CW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  assign delta = (div_b == '0 || div_q == '0) ? CW'(1) : div_q;
  assign p_sum = SW'(p_r) + SW'(delta);

  always_comb begin
    if (!ghost_b2_r) begin
      p_new = (p_sum > c_w) ? cap_eff : PW'(p_sum);
    end else if (SW'(p_r) >= SW'(delta)) begin
      p_new = PW'(SW'(p_r) - SW'(delta));
    end else begin
      p_new = '0;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      arc_pkg::ST_IDLE: begin
        if (in_acc) state_nxt = arc_pkg::ST_SCAN;
      end
      arc_pkg::ST_SCAN: begin
        if (scan_cnt_r == IW'(SLOT_COUNT - 1)) state_nxt = arc_pkg::ST_SCAN_END;
      end
      arc_pkg::ST_SCAN_END: state_nxt = arc_pkg::ST_RDVAL;
      arc_pkg::ST_RDVAL:    state_nxt = arc_pkg::ST_DECIDE;
      arc_pkg::ST_DECIDE: begin
        if (in_q_r.cmd == arc_pkg::CMD_GET && !found_r) begin
          state_nxt = arc_pkg::ST_FIN;
        end else if (dec_res) begin
          state_nxt = arc_pkg::ST_SELF_DET;
        end else if (dec_ghost) begin
          state_nxt = arc_pkg::ST_DIV;
        end else if (m_drop) begin
          state_nxt = arc_pkg::ST_DROP;
        end else if (m_repl) begin
          state_nxt = arc_pkg::ST_REPL_DET;
        end else begin
          state_nxt = arc_pkg::ST_PUSH;
        end
      end
      arc_pkg::ST_DIV: begin
        if (div_done) state_nxt = arc_pkg::ST_ADAPT;
      end
      arc_pkg::ST_ADAPT: state_nxt = arc_pkg::ST_REPL_DET;
      arc_pkg::ST_DROP: begin
        state_nxt = do_repl_r ? arc_pkg::ST_REPL_DET : arc_pkg::ST_PUSH;
      end
      arc_pkg::ST_REPL_DET: begin
        if (tail_ok) begin
          state_nxt = arc_pkg::ST_REPL_PUSH;
        end else begin
          state_nxt = ghost_r ? arc_pkg::ST_SELF_DET : arc_pkg::ST_PUSH;
        end
      end
      arc_pkg::ST_REPL_PUSH: begin
        state_nxt = ghost_r ? arc_pkg::ST_SELF_DET : arc_pkg::ST_PUSH;
      end
      arc_pkg::ST_SELF_DET: state_nxt = arc_pkg::ST_PUSH;
      arc_pkg::ST_PUSH:     state_nxt = arc_pkg::ST_FIN;
      arc_pkg::ST_FIN: begin
        if (!out_valid_r || !out_stall) state_nxt = arc_pkg::ST_IDLE;
      end
      default: state_nxt = arc_pkg::ST_IDLE;
    endcase
  end

  // Datapath controls per state
  always_comb begin
    det_en    = 1'b0;
    det_slot  = s_r;
    push_en   = 1'b0;
    push_slot = s_r;
    push_lst  = arc_pkg::LST_T2;
    mem_we    = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      arc_pkg::ST_DECIDE: begin
        div_start = dec_ghost;
      end
      arc_pkg::ST_DROP, arc_pkg::ST_REPL_DET: begin
        det_en   = tail_ok;
        det_slot = tail_idx;
      end
      arc_pkg::ST_REPL_PUSH: begin
        push_en   = 1'b1;
        push_slot = tail_r;
        push_lst  = to_lst_r;
      end
      arc_pkg::ST_SELF_DET: begin
        det_en = 1'b1;
      end
      arc_pkg::ST_PUSH: begin
        push_slot = res_r ? s_r : free_idx;
        push_en   = res_r || free_ok;
        push_lst  = (res_r || ghost_r) ? arc_pkg::LST_T2 : arc_pkg::LST_T1;
        mem_we    = push_en;
      end
      arc_pkg::ST_FIN: begin
        out_load = !out_valid_r || !out_stall;
      end
      default: begin
        det_en = 1'b0;
      end
    endcase
  end

  // Detach closes the gap behind the slot; push shifts the list down a rank
  assign det_l    = list_r[det_slot];
  assign det_rank = rank_r[det_slot];

  always_comb begin
    list_nxt   = list_r;
    rank_nxt   = rank_r;
    counts_nxt = counts_r;
    if (det_en && det_l != arc_pkg::LST_EMPTY && det_l <= arc_pkg::LST_B2) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (list_r[i] == det_l && rank_r[i] > det_rank) begin
          rank_nxt[i] = rank_r[i] - 1'b1;
        end
      end
      if (counts_r[2'(det_l - 3'd1)] != '0) begin
        counts_nxt[2'(det_l - 3'd1)] = counts_r[2'(det_l - 3'd1)] - 1'b1;
      end
      list_nxt[det_slot] = arc_pkg::LST_EMPTY;
      rank_nxt[det_slot] = '0;
    end
    if (push_en) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (list_r[i] == push_lst) rank_nxt[i] = rank_r[i] + 1'b1;
      end
      list_nxt[push_slot] = push_lst;
      rank_nxt[push_slot] = '0;
      counts_nxt[2'(push_lst - 3'd1)] = counts_r[2'(push_lst - 3'd1)] + 1'b1;
    end
  end

  // Control and list state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= arc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      cap_r       <= arc_pkg::CAP_W'(CAPACITY_MAX_RESET);
      p_r         <= '0;
      found_r     <= 1'b0;
      cmp_v_r     <= 1'b0;
      scan_cnt_r  <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        list_r[i] <= arc_pkg::LST_EMPTY;
        rank_r[i] <= '0;
      end
      for (int j = 0; j < 4; j++) counts_r[j] <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
      cmp_v_r <= (state_r == arc_pkg::ST_SCAN);
      if (in_acc) begin
        found_r    <= 1'b0;
        scan_cnt_r <= '0;
      end else if (state_r == arc_pkg::ST_SCAN) begin
        scan_cnt_r <= scan_cnt_r + 1'b1;
      end
      // Keep the first occupied slot whose key matches
      if (cmp_v_r && !found_r && list_r[cmp_idx_r] != arc_pkg::LST_EMPTY &&
          key_q_r == in_q_r.key) begin
        found_r <= 1'b1;
      end
      if (cfg_we) begin
        // Capacity change empties every list and clears p
        cap_r <= cfg_data;
        p_r   <= '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
          list_r[i] <= arc_pkg::LST_EMPTY;
          rank_r[i] <= '0;
        end
        for (int j = 0; j < 4; j++) counts_r[j] <= '0;
      end else begin
        if (state_r == arc_pkg::ST_ADAPT) p_r <= p_new;
        list_r   <= list_nxt;
        rank_r   <= rank_nxt;
        counts_r <= counts_nxt;
      end
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    if (in_acc) in_q_r <= in_data;
    cmp_idx_r <= scan_cnt_r;
    if (cmp_v_r && !found_r && list_r[cmp_idx_r] != arc_pkg::LST_EMPTY &&
        key_q_r == in_q_r.key) begin
      s_r <= cmp_idx_r;
    end
    if (state_r == arc_pkg::ST_DECIDE) begin
      res_r      <= dec_res;
      ghost_r    <= dec_ghost;
      ghost_b2_r <= (s_lst == arc_pkg::LST_B2);
      hit_r      <= dec_res;
      do_repl_r  <= m_repl;
      drop_lst_r <= m_drop_lst;
      if (in_q_r.cmd == arc_pkg::CMD_GET && dec_res) begin
        rv_r   <= val_q_r;
        wval_r <= val_q_r;
      end else begin
        rv_r   <= '0;
        wval_r <= in_q_r.write_value;
      end
    end
    if (state_r == arc_pkg::ST_REPL_DET) begin
      tail_r   <= tail_idx;
      to_lst_r <= rep_from + 3'd2;
    end
    if (out_load) begin
      out_data_r.hit        <= hit_r;
      out_data_r.read_value <= rv_r;
    end
  end

  // Key and value memories: one write port, one registered read each
  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[push_slot] <= in_q_r.key;
      val_mem[push_slot] <= wval_r;
    end
    key_q_r <= key_mem[scan_cnt_r];
    val_q_r <= val_mem[s_r];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ARC_ASSERT(a_p_within_cap, p_r <= cap_eff)
  `ARC_ASSERT(a_div_only_in_div, !div_done || state_r == arc_pkg::ST_DIV)
  `ARC_ASSERT_NEXT(a_accept_starts_scan, in_acc && !cfg_we, state_r == arc_pkg::ST_SCAN)

endmodule

// File: verif/adaptive_replacement_cache_core_tb.sv
module adaptive_replacement_cache_core_tb;

  localparam int SLOTS = arc_pkg::SLOT_COUNT_DEF;
  localparam int CMAX = arc_pkg::CAPACITY_MAX_DEF;
  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 120;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  arc_pkg::in_t in_data;
  logic out_valid;
  logic out_stall;
  arc_pkg::out_t out_data;
  logic cfg_we;
  logic [arc_pkg::CAP_W-1:0] cfg_data;

  adaptive_replacement_cache_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // Mirror of the cache state: per-slot key, value, list and rank, list lengths,
  // target T1 size and the capacity register.
  logic [31:0] m_key [SLOTS];
  logic [31:0] m_val [SLOTS];
  logic [2:0] m_list [SLOTS];
  int unsigned m_rank [SLOTS];
  int unsigned m_len [1:4];
  int unsigned m_target;
  logic [arc_pkg::CAP_W-1:0] m_cap;

  arc_pkg::in_t pending_items[$];
  arc_pkg::out_t expected_results[$];
  int n_accepted, n_checked, n_hits, n_mismatch, idle_cycles;
  int in_gap, stall_len;
  bit calm;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Mostly short gaps, a few long ones; none at all while calm.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(12, 45);
  endfunction

  function automatic int unsigned eff_capacity();
    if (m_cap == 0) return 1;
    if (m_cap > CMAX) return CMAX;
    return 32'(m_cap);
  endfunction

  function automatic void flush_cache();
    for (int i = 0; i < SLOTS; i++) begin
      m_list[i] = arc_pkg::LST_EMPTY;
      m_rank[i] = 0;
    end
    for (int l = 1; l <= 4; l++) m_len[l] = 0;
    m_target = 0;
  endfunction

  function automatic int find_slot(logic [31:0] k);
    for (int i = 0; i < SLOTS; i++)
      if (m_list[i] != arc_pkg::LST_EMPTY && m_key[i] == k) return i;
    return -1;
  endfunction

  function automatic void unlink(int s);
    logic [2:0] l;
    l = m_list[s];
    if (l == arc_pkg::LST_EMPTY) return;
    for (int i = 0; i < SLOTS; i++)
      if (m_list[i] == l && m_rank[i] > m_rank[s]) m_rank[i]--;
    if (m_len[l] > 0) m_len[l]--;
    m_list[s] = arc_pkg::LST_EMPTY;
    m_rank[s] = 0;
  endfunction

  function automatic void link_mru(int s, logic [2:0] l);
    for (int i = 0; i < SLOTS; i++)
      if (m_list[i] == l) m_rank[i]++;
    m_list[s] = l;
    m_rank[s] = 0;
    m_len[l]++;
  endfunction

  function automatic int lru_slot(logic [2:0] l);
    if (m_len[l] == 0) return -1;
    for (int i = 0; i < SLOTS; i++)
      if (m_list[i] == l && m_rank[i] == m_len[l] - 1) return i;
    return -1;
  endfunction

  function automatic void drop_lru(logic [2:0] l);
    int t;
    t = lru_slot(l);
    if (t >= 0) unlink(t);
  endfunction

  function automatic void demote_lru(logic [2:0] from, logic [2:0] to);
    int t;
    t = lru_slot(from);
    if (t < 0) return;
    unlink(t);
    link_mru(t, to);
  endfunction

  // Evict one resident entry into its ghost list, steered by the target size.
  function automatic void evict_resident(bit from_b2);
    int unsigned t1;
    t1 = m_len[arc_pkg::LST_T1];
    if (t1 >= 1 && ((from_b2 && t1 == m_target) || t1 > m_target))
      demote_lru(arc_pkg::LST_T1, arc_pkg::LST_B1);
    else
      demote_lru(arc_pkg::LST_T2, arc_pkg::LST_B2);
  endfunction

  function automatic void place_entry(logic [31:0] k, logic [31:0] v, logic [2:0] l);
    for (int i = 0; i < SLOTS; i++)
      if (m_list[i] == arc_pkg::LST_EMPTY) begin
        m_key[i] = k;
        m_val[i] = v;
        link_mru(i, l);
        return;
      end
  endfunction

  function automatic void access_entry(logic [31:0] k, logic [31:0] v);
    int unsigned c, b1, b2, step, t1, t1b1, total;
    int s;
    c = eff_capacity();
    s = find_slot(k);
    b1 = m_len[arc_pkg::LST_B1];
    b2 = m_len[arc_pkg::LST_B2];
    if (s >= 0) begin
      if (m_list[s] == arc_pkg::LST_T1 || m_list[s] == arc_pkg::LST_T2) begin
        unlink(s);
        link_mru(s, arc_pkg::LST_T2);
        m_val[s] = v;
        return;
      end
      // Ghost hit: adapt the target by the ghost length ratio, then make room.
      if (m_list[s] == arc_pkg::LST_B1) begin
        step = (b1 == 0) ? 1 : b2 / b1;
        if (step < 1) step = 1;
        m_target = (m_target + step > c) ? c : m_target + step;
        evict_resident(1'b0);
      end else begin
        step = (b2 == 0) ? 1 : b1 / b2;
        if (step < 1) step = 1;
        m_target = (m_target >= step) ? m_target - step : 0;
        evict_resident(1'b1);
      end
      unlink(s);
      place_entry(k, v, arc_pkg::LST_T2);
      return;
    end
    t1 = m_len[arc_pkg::LST_T1];
    t1b1 = t1 + m_len[arc_pkg::LST_B1];
    total = t1b1 + m_len[arc_pkg::LST_T2] + m_len[arc_pkg::LST_B2];
    if (t1b1 == c) begin
      if (t1 < c) begin
        drop_lru(arc_pkg::LST_B1);
        evict_resident(1'b0);
      end else begin
        drop_lru(arc_pkg::LST_T1);
      end
    end else if (t1b1 < c && total >= c) begin
      if (total == 2 * c) drop_lru(arc_pkg::LST_B2);
      evict_resident(1'b0);
    end
    place_entry(k, v, arc_pkg::LST_T1);
  endfunction

  function automatic arc_pkg::out_t lookup_result(arc_pkg::in_t it);
    arc_pkg::out_t r;
    int s;
    s = find_slot(it.key);
    r.hit = (s >= 0) && (m_list[s] == arc_pkg::LST_T1 || m_list[s] == arc_pkg::LST_T2);
    r.read_value = '0;
    if (it.cmd == arc_pkg::CMD_PUT) begin
      access_entry(it.key, it.write_value);
    end else if (s >= 0) begin
      if (r.hit) begin
        r.read_value = m_val[s];
        access_entry(it.key, m_val[s]);
      end else begin
        access_entry(it.key, it.write_value);
      end
    end
    return r;
  endfunction

  // Input driver: predict on acceptance, then advance to the next item or a gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(lookup_result(in_data));
        n_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_valid <= 1'b0;
          in_gap <= in_gap - 1;
        end else if (pending_items.size() > 0) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
          in_gap <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver backpressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_len <= 0;
    end else if (stall_len > 0) begin
      out_stall <= 1'b1;
      stall_len <= stall_len - 1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 3) == 0) stall_len <= pick_gap();
    end
  end

  // Result monitor: compare each item against the oldest prediction.
  always @(posedge clk) begin
    arc_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("unexpected result: hit=%0b read_value=%0d",
                   out_data.hit, out_data.read_value);
      end else begin
        want = expected_results.pop_front();
        n_checked++;
        if (want.hit) n_hits++;
        if (out_data.hit !== want.hit || out_data.read_value !== want.read_value) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch at result %0d: hit exp %0b got %0b, read_value exp %0d got %0d",
                     n_checked, want.hit, out_data.hit, want.read_value,
                     out_data.read_value);
        end
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      idle_cycles <= 0;
    else if (pending_items.size() > 0 || expected_results.size() > 0 || in_valid) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
        $display("status: fail");
        $finish;
      end
    end else
      idle_cycles <= 0;
  end

  task automatic queue_item(logic cmd, logic [31:0] k, logic [31:0] v);
    arc_pkg::in_t it;
    it.cmd = cmd;
    it.key = k;
    it.write_value = v;
    pending_items.push_back(it);
  endtask

  // Small key pools keep hits and ghost hits frequent; some keys are fully random.
  task automatic queue_random(int n, int unsigned pool);
    logic [31:0] k;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) k = $urandom();
      else k = 32'hA5A5_0000 + $urandom_range(0, pool - 1);
      queue_item(1'($urandom_range(0, 1)), k, $urandom());
    end
  endtask

  // Hold until every item is accepted and answered, then let the block settle.
  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_capacity(logic [arc_pkg::CAP_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    m_cap = v;
    flush_cache();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [arc_pkg::CAP_W-1:0] caps[6];
    caps = '{5'd1, 5'd0, 5'd31, 5'd3, 5'd8, 5'd16};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    calm = 1'b0;
    n_accepted = 0;
    n_checked = 0;
    n_hits = 0;
    n_mismatch = 0;
    m_cap = 5'd16;
    flush_cache();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, get hit and miss, T1 to T2 promotion, T2 refresh.
    queue_item(arc_pkg::CMD_GET, 32'h0000_0000, 32'h7FFF_FFFF);
    queue_item(arc_pkg::CMD_PUT, 32'h0000_0000, 32'h7FFF_FFFF);
    queue_item(arc_pkg::CMD_GET, 32'h0000_0000, 32'h0);
    queue_item(arc_pkg::CMD_PUT, 32'hFFFF_FFFF, 32'h8000_0000);
    queue_item(arc_pkg::CMD_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_item(arc_pkg::CMD_PUT, 32'h0000_0000, 32'h0000_0001);
    queue_item(arc_pkg::CMD_GET, 32'h0000_0000, 32'h0);
    queue_item(arc_pkg::CMD_GET, 32'h1234_5678, 32'h5555_5555);
    drain();

    // Capacity of one: every new key evicts, so ghost hits come quickly.
    set_capacity(5'd1);
    queue_item(arc_pkg::CMD_PUT, 32'hA, 32'd10);
    queue_item(arc_pkg::CMD_PUT, 32'hB, 32'd11);
    queue_item(arc_pkg::CMD_GET, 32'hA, 32'd12);
    queue_item(arc_pkg::CMD_PUT, 32'hC, 32'd13);
    queue_item(arc_pkg::CMD_GET, 32'hA, 32'd14);
    queue_item(arc_pkg::CMD_GET, 32'hB, 32'd15);
    queue_item(arc_pkg::CMD_PUT, 32'hA, 32'd16);
    queue_item(arc_pkg::CMD_GET, 32'hC, 32'd17);
    queue_item(arc_pkg::CMD_GET, 32'hD, 32'd18);
    drain();

    // Random phases across capacity settings, including out-of-range ones.
    for (int ph = 0; ph < 6; ph++) begin
      set_capacity(caps[ph]);
      calm = (ph == 2);
      queue_random(90, (caps[ph] == 0 ? 1 : (caps[ph] > 16 ? 16 : caps[ph])) * 3 + 2);
      drain();
    end
    calm = 1'b0;
    queue_random(20, 40);
    drain();

    $display("covered %0d items over 8 capacity settings, %0d resident hits",
             n_checked, n_hits);
    if (n_mismatch == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", n_mismatch);
      $display("status: fail");
    end
    $finish;
  end

endmodule
